@@ hw/rtl/qpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared constants for the quaternion product and rotation core: default
// widths, operation codes and component positions within a quaternion.
// ----------------------------------------------------------------------------
package qpr_pkg;

	localparam int WIDTH_DEF     = 16;
	localparam int FRAC_BITS_DEF = 12;

	localparam logic OP_PRODUCT = 1'b0;
	localparam logic OP_ROTATE  = 1'b1;

	// Component positions inside a packed quaternion, real part first.
	localparam int C_W = 0;
	localparam int C_X = 1;
	localparam int C_Y = 2;
	localparam int C_Z = 3;

endpackage

@@ hw/rtl/qpr_hamilton.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_hamilton
// Three-stage Hamilton product p*q: sixteen registered products, registered
// signed sums with the rounding constant, then shift and saturation. A tag
// travels with each item unchanged.
// ----------------------------------------------------------------------------
module qpr_hamilton
	import qpr_pkg::*;
#(
	parameter int PW = 16,
	parameter int QW = 16,
	parameter int W  = 16,
	parameter int F  = 12,
	parameter int TW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0][PW-1:0]  p,
	input  logic [3:0][QW-1:0]  q,
	input  logic [TW-1:0]       tag_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0][W-1:0]   r,
	output logic [3:0]          sat,
	output logic [TW-1:0]       tag_out
);

	localparam int PQ = PW + QW;
	localparam int SW = PQ + 2;
	// The sum is widened so that the shifted value always covers W bits.
	localparam int EW = ((SW > F + W) ? SW : F + W) + 1;

	localparam logic signed [EW-1:0] RND  = EW'(1) << (F - 1);
	localparam logic signed [EW-1:0] MAXV = (EW'(1) << (W - 1)) - EW'(1);
	localparam logic signed [EW-1:0] MINV = -(EW'(1) << (W - 1));

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	logic signed [PQ-1:0] prod_s1 [16];
	logic [TW-1:0]        tag_s1, tag_s2;
	logic signed [EW-1:0] sum_s2 [4];
	logic signed [EW-1:0] sum_d [4];
	logic signed [EW-1:0] e [16];

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: every product p_i * q_j, index i*4+j.
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i*4+j] <= PQ'($signed(p[i]) * $signed(q[j]));
				end
			end
			tag_s1 <= tag_in;
		end
	end

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			e[k] = EW'(prod_s1[k]);
		end
		sum_d[C_W] = e[0]  - e[5]  - e[10] - e[15] + RND;
		sum_d[C_X] = e[1]  + e[4]  + e[11] - e[14] + RND;
		sum_d[C_Y] = e[2]  + e[8]  + e[13] - e[7]  + RND;
		sum_d[C_Z] = e[3]  + e[12] + e[6]  - e[9]  + RND;
	end

	// Stage 2: signed sums with the half-LSB rounding constant.
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			for (int i = 0; i < 4; i++) begin
				sum_s2[i] <= sum_d[i];
			end
			tag_s2 <= tag_s1;
		end
	end

	// Stage 3: arithmetic shift and clip to W bits.
	always_ff @(posedge clk) begin
		logic signed [EW-1:0] sh;
		if (adv3 && v_s2) begin
			for (int i = 0; i < 4; i++) begin
				sh = sum_s2[i] >>> F;
				if (sh > MAXV) begin
					r[i]   <= MAXV[W-1:0];
					sat[i] <= 1'b1;
				end else if (sh < MINV) begin
					r[i]   <= MINV[W-1:0];
					sat[i] <= 1'b1;
				end else begin
					r[i]   <= sh[W-1:0];
					sat[i] <= 1'b0;
				end
			end
			tag_out <= tag_s2;
		end
	end

endmodule

@@ hw/rtl/quaternion_product_rotate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_rotate_core
// Hamilton product a*b, or rotation of vector b by a as a*(0,b)*conj(a),
// in signed fixed point with rounding, saturation and a clip flag.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------
//   input   | in_valid / in_ready  | op, a_w..a_z, b_w..b_z
//   output  | out_valid / out_ready| r_w..r_z, saturated
//
// One item enters per cycle while the output is not held back. Each item passes
// through six register stages: two three-stage Hamilton product units
// in series (multiply, sum, round and saturate). Reset clears only the stage
// valid bits. A stage holds its item while the next stage is full and not
// moving, so empty stages keep filling while a result waits at the output.
// ----------------------------------------------------------------------------
module quaternion_product_rotate_core
	import qpr_pkg::*;
#(
	parameter int WIDTH     = WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic signed [WIDTH-1:0] a_w,
	input  logic signed [WIDTH-1:0] a_x,
	input  logic signed [WIDTH-1:0] a_y,
	input  logic signed [WIDTH-1:0] a_z,
	input  logic signed [WIDTH-1:0] b_w,
	input  logic signed [WIDTH-1:0] b_x,
	input  logic signed [WIDTH-1:0] b_y,
	input  logic signed [WIDTH-1:0] b_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [WIDTH-1:0] r_w,
	output logic signed [WIDTH-1:0] r_x,
	output logic signed [WIDTH-1:0] r_y,
	output logic signed [WIDTH-1:0] r_z,
	output logic                    saturated
);

	localparam int QV   = 4 * WIDTH;
	localparam int TW1  = 1 + QV;
	localparam int TW2  = 2 + QV;

	logic [3:0][WIDTH-1:0] a_q, b_q, t_q, u2_r;
	logic [3:0][WIDTH:0]   ac_q;
	logic [TW1-1:0]        tag1_in, tag1_out;
	logic [TW2-1:0]        tag2_in, tag2_out;
	logic [3:0]            sat1, sat2;
	logic                  u1_valid, u1_ready;
	logic                  rot_o, sat1_o;
	logic [QV-1:0]         t_o;
	logic [3:0][WIDTH-1:0] t_unp;

	always_comb begin
		a_q[C_W] = a_w;
		a_q[C_X] = a_x;
		a_q[C_Y] = a_y;
		a_q[C_Z] = a_z;
		// The real part of b is dropped for a rotation.
		b_q[C_W] = (op == OP_ROTATE) ? '0 : b_w;
		b_q[C_X] = b_x;
		b_q[C_Y] = b_y;
		b_q[C_Z] = b_z;
	end

	assign tag1_in = {op, a_q};

	qpr_hamilton #(
		.PW(WIDTH), .QW(WIDTH), .W(WIDTH), .F(FRAC_BITS), .TW(TW1)
	) u_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.p        (a_q),
		.q        (b_q),
		.tag_in   (tag1_in),
		.out_valid(u1_valid),
		.out_ready(u1_ready),
		.r        (t_q),
		.sat      (sat1),
		.tag_out  (tag1_out)
	);

	// Conjugate of a at one extra bit, so the most negative value negates exactly.
	always_comb begin
		logic [3:0][WIDTH-1:0] a_t;
		a_t = tag1_out[QV-1:0];
		ac_q[C_W] = (WIDTH+1)'($signed(a_t[C_W]));
		for (int i = 1; i < 4; i++) begin
			ac_q[i] = -(WIDTH+1)'($signed(a_t[i]));
		end
	end

	assign tag2_in = {tag1_out[TW1-1], t_q, |sat1};

	qpr_hamilton #(
		.PW(WIDTH), .QW(WIDTH+1), .W(WIDTH), .F(FRAC_BITS), .TW(TW2)
	) u_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (u1_valid),
		.in_ready (u1_ready),
		.p        (t_q),
		.q        (ac_q),
		.tag_in   (tag2_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.r        (u2_r),
		.sat      (sat2),
		.tag_out  (tag2_out)
	);

	assign rot_o  = tag2_out[TW2-1];
	assign t_o    = tag2_out[QV:1];
	assign sat1_o = tag2_out[0];
	assign t_unp  = t_o;

	always_comb begin
		if (rot_o == OP_ROTATE) begin
			r_w       = '0;
			r_x       = u2_r[C_X];
			r_y       = u2_r[C_Y];
			r_z       = u2_r[C_Z];
			saturated = sat1_o | (|sat2[C_Z:C_X]);
		end else begin
			r_w       = t_unp[C_W];
			r_x       = t_unp[C_X];
			r_y       = t_unp[C_Y];
			r_z       = t_unp[C_Z];
			saturated = sat1_o;
		end
	end

`ifndef SYNTHESIS
	// With the output free to move, every stage can advance and the input is open.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled although the output stage can move");

	// A clip in the second product of a rotation must reach the flag.
	a_rot_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rot_o == OP_ROTATE && (sat2[C_X] || sat2[C_Y] || sat2[C_Z]))
		|-> saturated)
		else $error("rotation clip not reported");
`endif

endmodule
